### sv/dfd_pkg.sv
// ----------------------------------------------------------------------------
// dfd_pkg: shared constants for the deauthentication flood detector
// Frame codes, register indexes, register reset values and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dfd_pkg;

  // field widths
  localparam int MAC_W   = 48;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int CHAN_W  = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;

  // register reset values
  localparam logic               ENABLE_RST    = 1'b1;
  localparam logic [COUNT_W-1:0] THRESHOLD_RST = 16'd10;
  localparam logic [COUNT_W-1:0] WINDOW_RST    = 16'd1000;

  // 802.11 frame codes
  localparam logic [1:0] FT_MGMT      = 2'd0;
  localparam logic [3:0] ST_DISASSOC  = 4'd10;
  localparam logic [3:0] ST_DEAUTH    = 4'd12;

  // hold-off between two alerts of one slot
  localparam logic [TIME_W-1:0]  REALERT_MS = 32'd3000;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

endpackage

`default_nettype wire

### sv/dfd_cell.sv
// ----------------------------------------------------------------------------
// dfd_cell: one slot of the per-bssid rate table
// Holds one slot and refines the search word passing down the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module dfd_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  wire                           clk,
  input  wire                           rst,
  // bssid under search, held steady for the whole pass
  input  wire  [dfd_pkg::MAC_W-1:0]     bssid,
  // search word from the previous cell
  input  wire                           tok_in_valid,
  input  wire                           tok_in_match,
  input  wire  [IW-1:0]                 tok_in_match_idx,
  input  wire  [dfd_pkg::TIME_W-1:0]    tok_in_m_ws,
  input  wire  [dfd_pkg::COUNT_W-1:0]   tok_in_m_cnt,
  input  wire  [dfd_pkg::TIME_W-1:0]    tok_in_m_la,
  input  wire                           tok_in_free,
  input  wire  [IW-1:0]                 tok_in_free_idx,
  input  wire  [IW-1:0]                 tok_in_old_idx,
  input  wire  [dfd_pkg::TIME_W-1:0]    tok_in_old_ws,
  // search word to the next cell
  output logic                          tok_out_valid,
  output logic                          tok_out_match,
  output logic [IW-1:0]                 tok_out_match_idx,
  output logic [dfd_pkg::TIME_W-1:0]    tok_out_m_ws,
  output logic [dfd_pkg::COUNT_W-1:0]   tok_out_m_cnt,
  output logic [dfd_pkg::TIME_W-1:0]    tok_out_m_la,
  output logic                          tok_out_free,
  output logic [IW-1:0]                 tok_out_free_idx,
  output logic [IW-1:0]                 tok_out_old_idx,
  output logic [dfd_pkg::TIME_W-1:0]    tok_out_old_ws,
  // slot update broadcast
  input  wire                           wr_en,
  input  wire  [IW-1:0]                 wr_idx,
  input  wire  [dfd_pkg::MAC_W-1:0]     wr_bssid,
  input  wire  [dfd_pkg::TIME_W-1:0]    wr_ws,
  input  wire  [dfd_pkg::COUNT_W-1:0]   wr_cnt,
  input  wire  [dfd_pkg::TIME_W-1:0]    wr_la
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                        used;
  logic [dfd_pkg::MAC_W-1:0]   slot_bssid;
  logic [dfd_pkg::TIME_W-1:0]  slot_ws;
  logic [dfd_pkg::COUNT_W-1:0] slot_cnt;
  logic [dfd_pkg::TIME_W-1:0]  slot_la;

  logic                        hit;
  logic                        take_match;
  logic                        take_free;
  logic                        take_old;

  // compare this slot against the word
  assign hit        = used && (slot_bssid == bssid);
  assign take_match = !tok_in_match && hit;
  assign take_free  = !tok_in_free && !used;
  assign take_old   = (IDX == 0) || (slot_ws < tok_in_old_ws);

  // slot storage
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (wr_en && (wr_idx == MY_IDX)) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_IDX)) begin
      slot_bssid <= wr_bssid;
      slot_ws    <= wr_ws;
      slot_cnt   <= wr_cnt;
      slot_la    <= wr_la;
    end
  end

  // word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  // refined word to the neighbor
  always_ff @(posedge clk) begin
    tok_out_match     <= tok_in_match || hit;
    tok_out_match_idx <= take_match ? MY_IDX   : tok_in_match_idx;
    tok_out_m_ws      <= take_match ? slot_ws  : tok_in_m_ws;
    tok_out_m_cnt     <= take_match ? slot_cnt : tok_in_m_cnt;
    tok_out_m_la      <= take_match ? slot_la  : tok_in_m_la;
    tok_out_free      <= tok_in_free || !used;
    tok_out_free_idx  <= take_free ? MY_IDX : tok_in_free_idx;
    tok_out_old_idx   <= take_old ? MY_IDX  : tok_in_old_idx;
    tok_out_old_ws    <= take_old ? slot_ws : tok_in_old_ws;
  end

endmodule

`default_nettype wire

### sv/deauth_flood_detector_top.sv
// ----------------------------------------------------------------------------
// deauth_flood_detector_top: per-bssid deauth/disassoc flood detector
// Counts deauth and disassoc frames per bssid in windowed slots and alerts.
// ----------------------------------------------------------------------------
// Every accepted frame gives exactly one result word. For a counted frame the
// search word walks the row of SLOTS slot cells, registered in each cell, then
// the resolved slot and window state are registered, and then the slot is
// updated and the result register loaded once the output is free. The input
// is held off from acceptance until that update. Frames that are not counted
// load the result register from the skip state once the output is free, and
// return an all-zero result. A new frame is taken once the previous one has
// loaded its result and, if counted, written its slot, even while that result
// still waits on the output.
`default_nettype none

module deauth_flood_detector_top #(
  parameter int SLOTS = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  // configuration
  input  wire                              cfg_we,
  input  wire  [dfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [dfd_pkg::CFG_W-1:0]        cfg_data,
  // frame input
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [1:0]                       frame_type,
  input  wire  [3:0]                       frame_subtype,
  input  wire  [dfd_pkg::MAC_W-1:0]        receiver_addr,
  input  wire  [dfd_pkg::MAC_W-1:0]        transmitter_addr,
  input  wire                              transmitter_present,
  input  wire  [dfd_pkg::MAC_W-1:0]        bss_addr,
  input  wire                              bss_present,
  input  wire  [dfd_pkg::CHAN_W-1:0]       radio_channel,
  input  wire  [dfd_pkg::TIME_W-1:0]       now_ms,
  // result output
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             alert,
  output logic [dfd_pkg::COUNT_W-1:0]      frame_count,
  output logic [dfd_pkg::MAC_W-1:0]        target_bssid,
  output logic [dfd_pkg::MAC_W-1:0]        station,
  output logic                             station_valid,
  output logic [dfd_pkg::CHAN_W-1:0]       alert_channel
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SKIP = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_EVAL = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration registers
  logic                         enable;
  logic [dfd_pkg::COUNT_W-1:0]  threshold;
  logic [dfd_pkg::COUNT_W-1:0]  window_ms;

  // latched frame
  logic [dfd_pkg::MAC_W-1:0]    bssid_q;
  logic [dfd_pkg::MAC_W-1:0]    station_q;
  logic                         station_valid_q;
  logic [dfd_pkg::CHAN_W-1:0]   chan_q;
  logic [dfd_pkg::TIME_W-1:0]   now_q;

  logic in_acc;
  logic counted;
  logic out_free;
  logic scan_start;

  // search chain
  logic                        tok_valid     [0:SLOTS];
  logic                        tok_match     [0:SLOTS];
  logic [IW-1:0]               tok_match_idx [0:SLOTS];
  logic [dfd_pkg::TIME_W-1:0]  tok_m_ws      [0:SLOTS];
  logic [dfd_pkg::COUNT_W-1:0] tok_m_cnt     [0:SLOTS];
  logic [dfd_pkg::TIME_W-1:0]  tok_m_la      [0:SLOTS];
  logic                        tok_free      [0:SLOTS];
  logic [IW-1:0]               tok_free_idx  [0:SLOTS];
  logic [IW-1:0]               tok_old_idx   [0:SLOTS];
  logic [dfd_pkg::TIME_W-1:0]  tok_old_ws    [0:SLOTS];

  // resolved slot
  logic [IW-1:0]               sel_idx;
  logic [dfd_pkg::TIME_W-1:0]  base_ws;
  logic [dfd_pkg::COUNT_W-1:0] base_cnt;
  logic [dfd_pkg::TIME_W-1:0]  base_la;
  logic                        expired;
  logic                        realert;

  logic [IW-1:0]               res_idx;
  logic [dfd_pkg::TIME_W-1:0]  res_ws;
  logic [dfd_pkg::COUNT_W-1:0] res_cnt;
  logic [dfd_pkg::TIME_W-1:0]  res_la;
  logic [dfd_pkg::TIME_W-1:0]  ws_age;
  logic [dfd_pkg::TIME_W-1:0]  la_age;

  // update values
  logic [dfd_pkg::COUNT_W-1:0] cnt_base;
  logic [dfd_pkg::COUNT_W-1:0] cnt_new;
  logic [dfd_pkg::TIME_W-1:0]  ws_new;
  logic                        alert_new;
  logic [dfd_pkg::TIME_W-1:0]  la_new;
  logic                        wr_en;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign counted  = enable && (frame_type == dfd_pkg::FT_MGMT) &&
                    (frame_subtype inside {dfd_pkg::ST_DISASSOC, dfd_pkg::ST_DEAUTH});

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= dfd_pkg::ENABLE_RST;
      threshold <= dfd_pkg::THRESHOLD_RST;
      window_ms <= dfd_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dfd_pkg::REG_ENABLE:    enable    <= cfg_data[0];
        dfd_pkg::REG_THRESHOLD: threshold <= cfg_data;
        dfd_pkg::REG_WINDOW:    window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      bssid_q         <= bss_present ? bss_addr : receiver_addr;
      station_q       <= transmitter_present ? transmitter_addr : '0;
      station_valid_q <= transmitter_present;
      chan_q          <= radio_channel;
      now_q           <= now_ms;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc) state_next = counted ? S_SCAN : S_SKIP;
      S_SKIP: if (out_free) state_next = S_IDLE;
      S_SCAN: if (tok_valid[SLOTS]) state_next = S_EVAL;
      S_EVAL: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_start <= 1'b0;
    end else begin
      state      <= state_next;
      scan_start <= in_acc && counted;
    end
  end

  // chain head: empty search word
  assign tok_valid[0]     = scan_start;
  assign tok_match[0]     = 1'b0;
  assign tok_match_idx[0] = '0;
  assign tok_m_ws[0]      = '0;
  assign tok_m_cnt[0]     = '0;
  assign tok_m_la[0]      = '0;
  assign tok_free[0]      = 1'b0;
  assign tok_free_idx[0]  = '0;
  assign tok_old_idx[0]   = '0;
  assign tok_old_ws[0]    = '0;

  // row of slot cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    dfd_cell #(
      .IDX (g),
      .IW  (IW)
    ) u_cell (
      .clk               (clk),
      .rst               (rst),
      .bssid             (bssid_q),
      .tok_in_valid      (tok_valid[g]),
      .tok_in_match      (tok_match[g]),
      .tok_in_match_idx  (tok_match_idx[g]),
      .tok_in_m_ws       (tok_m_ws[g]),
      .tok_in_m_cnt      (tok_m_cnt[g]),
      .tok_in_m_la       (tok_m_la[g]),
      .tok_in_free       (tok_free[g]),
      .tok_in_free_idx   (tok_free_idx[g]),
      .tok_in_old_idx    (tok_old_idx[g]),
      .tok_in_old_ws     (tok_old_ws[g]),
      .tok_out_valid     (tok_valid[g+1]),
      .tok_out_match     (tok_match[g+1]),
      .tok_out_match_idx (tok_match_idx[g+1]),
      .tok_out_m_ws      (tok_m_ws[g+1]),
      .tok_out_m_cnt     (tok_m_cnt[g+1]),
      .tok_out_m_la      (tok_m_la[g+1]),
      .tok_out_free      (tok_free[g+1]),
      .tok_out_free_idx  (tok_free_idx[g+1]),
      .tok_out_old_idx   (tok_old_idx[g+1]),
      .tok_out_old_ws    (tok_old_ws[g+1]),
      .wr_en             (wr_en),
      .wr_idx            (sel_idx),
      .wr_bssid          (bssid_q),
      .wr_ws             (ws_new),
      .wr_cnt            (cnt_new),
      .wr_la             (la_new)
    );
  end

  // resolve slot: match, else first free, else oldest window start
  always_comb begin
    if (tok_match[SLOTS]) begin
      res_idx = tok_match_idx[SLOTS];
      res_ws  = tok_m_ws[SLOTS];
      res_cnt = tok_m_cnt[SLOTS];
      res_la  = tok_m_la[SLOTS];
    end else begin
      res_idx = tok_free[SLOTS] ? tok_free_idx[SLOTS] : tok_old_idx[SLOTS];
      res_ws  = now_q;
      res_cnt = '0;
      res_la  = '0;
    end
  end

  assign ws_age = now_q - res_ws;
  assign la_age = now_q - res_la;

  always_ff @(posedge clk) begin
    if (state == S_SCAN && tok_valid[SLOTS]) begin
      sel_idx  <= res_idx;
      base_ws  <= res_ws;
      base_cnt <= res_cnt;
      base_la  <= res_la;
      expired  <= ws_age > {{(dfd_pkg::TIME_W-dfd_pkg::COUNT_W){1'b0}}, window_ms};
      realert  <= la_age > dfd_pkg::REALERT_MS;
    end
  end

  // window restart, saturating count, alert decision
  assign cnt_base  = expired ? '0 : base_cnt;
  assign ws_new    = expired ? now_q : base_ws;
  assign cnt_new   = (cnt_base == dfd_pkg::COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
  assign alert_new = (cnt_new >= threshold) && realert;
  assign la_new    = alert_new ? now_q : base_la;
  assign wr_en     = (state == S_EVAL) && out_free;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EVAL || state == S_SKIP) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL && out_free) begin
      alert         <= alert_new;
      frame_count   <= cnt_new;
      target_bssid  <= bssid_q;
      station       <= station_q;
      station_valid <= station_valid_q;
      alert_channel <= chan_q;
    end else if (state == S_SKIP && out_free) begin
      alert         <= 1'b0;
      frame_count   <= '0;
      target_bssid  <= '0;
      station       <= '0;
      station_valid <= 1'b0;
      alert_channel <= '0;
    end
  end

endmodule

`default_nettype wire

### sv/dfd_checker.sv
// ----------------------------------------------------------------------------
// dfd_checker: port-level checks for the flood detector
// Watches the result channel and reset behavior from the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dfd_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire                            alert,
  input wire [dfd_pkg::COUNT_W-1:0]     frame_count,
  input wire [dfd_pkg::MAC_W-1:0]       target_bssid,
  input wire [dfd_pkg::MAC_W-1:0]       station,
  input wire                            station_valid,
  input wire [dfd_pkg::CHAN_W-1:0]      alert_channel
);

  // a stalled result word stays valid with its count and alert unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_count) && $stable(alert))
    else $error("result word dropped or changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word present after reset");

  // an alert always carries a nonzero count
  a_alert_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && alert |-> frame_count != '0)
    else $error("alert with zero count");

  // a frame that was not counted gives an all-zero word
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_count == '0 |-> !alert && target_bssid == '0 &&
      station == '0 && !station_valid && alert_channel == '0)
    else $error("uncounted frame with nonzero fields");

  // absent transmitter gives a zero station
  a_station_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !station_valid |-> station == '0)
    else $error("station set without transmitter address");

endmodule

bind deauth_flood_detector_top dfd_checker u_dfd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .alert         (alert),
  .frame_count   (frame_count),
  .target_bssid  (target_bssid),
  .station       (station),
  .station_valid (station_valid),
  .alert_channel (alert_channel)
);

`default_nettype wire
